@@ rtl/hte_pkg.sv @@
// Shared constants, codes and control types for the Huffman table encoder.
// No dependencies; every file of the block but hte_ram uses this package.
package hte_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int SYM_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 3;
  localparam int TOP_BIT = 7;
  localparam int SH_W    = $clog2(CODE_W);
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENTRY_W = CODE_W + LEN_W;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_PACK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic align;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic emits;
    logic rem_done;
    logic out_free;
  } status_t;

endpackage

@@ rtl/hte_if.sv @@
// Handshake channels of the encoder: input items and packed output bytes.
// Depends on hte_pkg for field widths.
interface hte_item_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [hte_pkg::SYM_W-1:0]   symbol;
  logic [hte_pkg::CODE_W-1:0]  code_word;
  logic [hte_pkg::LEN_W-1:0]   code_length;

  modport source (output valid, operation, symbol, code_word, code_length, input ready);
  modport sink   (input valid, operation, symbol, code_word, code_length, output ready);
endinterface

interface hte_result_if;
  logic                        valid;
  logic                        ready;
  logic [hte_pkg::BYTE_W-1:0]  out_byte;
  logic                        last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

@@ rtl/hte_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/hte_ctrl.sv @@
// Sequencer of the encoder: accepts words and steps the datapath.
// Depends on hte_pkg (state, operation codes, command and status types).
module hte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [1:0]        operation,
  output logic              item_ready,
  output hte_pkg::cmd_t     cmd,
  input  hte_pkg::status_t  status
);
  import hte_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          unique case (op_t'(operation))
            OP_LOAD:   cmd.load = 1'b1;
            OP_ENCODE: begin
              cmd.read   = 1'b1;
              state_next = ST_ALIGN;
            end
            OP_FLUSH:  state_next = ST_FLUSH;
            default:   ;
          endcase
        end
      end
      ST_ALIGN: begin
        cmd.align  = 1'b1;
        state_next = status.len_zero ? ST_IDLE : ST_PACK;
      end
      ST_PACK: begin
        // a step that completes a byte waits for the output slot
        if (!status.emits || status.out_free) begin
          cmd.step = 1'b1;
          if (status.rem_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/hte_datapath.sv @@
// Code table, bit packer and output byte register of the encoder.
// Depends on hte_pkg and hte_ram.
module hte_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  hte_pkg::cmd_t               cmd,
  output hte_pkg::status_t            status,
  input  logic [hte_pkg::SYM_W-1:0]   symbol,
  input  logic [hte_pkg::CODE_W-1:0]  code_word,
  input  logic [hte_pkg::LEN_W-1:0]   code_length,
  input  logic                        result_ready,
  output logic                        result_valid,
  output logic [hte_pkg::BYTE_W-1:0]  out_byte,
  output logic                        last_of_run
);
  import hte_pkg::*;

  logic               sym_ok, sym_ok_q;
  logic [LEN_W-1:0]   len_sat;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [LEN_W-1:0]   eff_len;
  logic [LEN_W-1:0]   shamt;
  logic [CODE_W-1:0]  code_reg;
  logic [LEN_W-1:0]   n_rem;
  logic [BYTE_W-1:0]  pending;
  logic [POS_W-1:0]   pos;
  logic [POS_W:0]     pos_plus;
  logic [POS_W:0]     k;
  logic [LEN_W-1:0]   rem_after;
  logic [BYTE_W-1:0]  pack_byte;
  logic               out_free;
  logic               emit;

  assign sym_ok  = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign len_sat = (code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length;

  hte_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.load && sym_ok),
    .waddr (symbol[ADDR_W-1:0]),
    .wdata ({len_sat, code_word}),
    .re    (cmd.read),
    .raddr (symbol[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // code is left aligned so the next bit is always the msb; zeros shift in
  assign eff_len = sym_ok_q ? ram_rdata[ENTRY_W-1:CODE_W] : '0;
  assign shamt   = LEN_W'(CODE_W) - eff_len;

  assign pos_plus  = {1'b0, pos} + (POS_W + 1)'(1);
  assign k         = (n_rem < LEN_W'(pos_plus)) ? n_rem[POS_W:0] : pos_plus;
  assign rem_after = n_rem - LEN_W'(k);
  assign pack_byte = pending | (code_reg[CODE_W-1 -: BYTE_W] >> (~pos));
  assign out_free  = !result_valid || result_ready;
  assign emit      = (cmd.step && status.emits) ||
                     (cmd.flush && (pos != POS_W'(TOP_BIT)));

  assign status.len_zero = (eff_len == '0);
  assign status.emits    = (k == pos_plus);
  assign status.rem_done = (rem_after == '0);
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= '0;
      pos          <= POS_W'(TOP_BIT);
      result_valid <= 1'b0;
    end else begin
      if (cmd.step) begin
        if (status.emits) begin
          pending <= '0;
          pos     <= POS_W'(TOP_BIT);
        end else begin
          pending <= pack_byte;
          pos     <= pos - k[POS_W-1:0];
        end
      end else if (cmd.flush) begin
        pending <= '0;
        pos     <= POS_W'(TOP_BIT);
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      sym_ok_q <= sym_ok;
    end
    if (cmd.align) begin
      code_reg <= ram_rdata[CODE_W-1:0] << shamt[SH_W-1:0];
      n_rem    <= eff_len;
    end else if (cmd.step) begin
      code_reg <= code_reg << k;
      n_rem    <= rem_after;
    end
    if (emit) begin
      out_byte    <= cmd.step ? pack_byte : pending;
      // fewer than eight bits left cannot fill another byte
      last_of_run <= cmd.step ? (rem_after < LEN_W'(BYTE_W)) : 1'b1;
    end
  end

endmodule

@@ rtl/huffman_table_encoder.sv @@
// Top level of the table-driven Huffman byte encoder with msb-first packing.
// Depends on hte_pkg, hte_if, hte_ctrl, hte_datapath (and hte_ram below it).
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ----------------------------------------------
//  item     in   valid / ready  operation, symbol, code_word, code_length
//  result   out  valid / ready  out_byte, last_of_run
//
// A load word is written into the code table as it is accepted.
// An encode word goes through a registered table read and a code alignment,
// then one packing step per byte boundary touched, at most 5 for a 32-bit
// code; the packer hands over one byte per cycle while the output is free.
// Flush waits for a free output. Reset (rst, synchronous) empties the packer;
// the code table keeps no reset and must be loaded before use.
// A full output register with result.ready low stalls a step that completes
// a byte and any flush, even one with no partial byte to hand over; other
// steps and table loads carry on.
module huffman_table_encoder (
  input logic          clk,
  input logic          rst,
  hte_item_if.sink     item,
  hte_result_if.source result
);
  import hte_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: owns the input handshake, issues at most one command a cycle
  hte_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .operation  (item.operation),
    .item_ready (item.ready),
    .cmd        (cmd),
    .status     (status)
  );

  // table, packer and output byte register
  hte_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .symbol       (item.symbol),
    .code_word    (item.code_word),
    .code_length  (item.code_length),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .out_byte     (result.out_byte),
    .last_of_run  (result.last_of_run)
  );

  // a completing step never overwrites a byte still waiting in the output
  a_step_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.emits) |-> status.out_free)
    else $error("packer emitted into an occupied output register");

  a_flush_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |-> status.out_free)
    else $error("flush emitted into an occupied output register");

  // an accepted encode word holds off the next word while it is packed
  a_encode_busy: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && (item.operation == OP_ENCODE)) |=> !item.ready)
    else $error("new word taken during an encode");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.read, cmd.align, cmd.step, cmd.flush}))
    else $error("more than one datapath command in a cycle");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for huffman_table_encoder: directed table, then random words.
// Depends on rtl/hte_pkg.sv, rtl/hte_if.sv and the encoder RTL from the top down.
`timescale 1ns / 1ps

module tb_top;
  import hte_pkg::*;

  // Operation code three has no meaning; the block must drop such a word.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int WORDS_PER_PHASE = 130;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 10;

  // One row of the directed table. Where `typed` is set, the expected bytes are
  // written out by hand (first byte in [31:24]) instead of taken from the predictor.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
    logic        typed;
    logic [2:0]  n_bytes;
    logic [31:0] bytes;
  } row_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } byte_due_t;

  localparam int N_ROWS = 26;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000}, // empty packer
    '{OP_LOAD,   8'h41, 32'h0000_00A5, 6'd8,  1'b0, 3'd0, 32'h0000_0000},
    '{OP_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hA500_0000}, // exactly one byte
    '{OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0, 3'd0, 32'h0000_0000},
    '{OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF}, // longest code
    '{OP_LOAD,   8'hFF, 32'h0000_0000, 6'd63, 1'b0, 3'd0, 32'h0000_0000}, // length saturates
    '{OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'h0000_0000},
    '{OP_LOAD,   8'h10, 32'h0000_0001, 6'd1,  1'b0, 3'd0, 32'h0000_0000},
    '{OP_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000}, // one bit, no byte
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h8000_0000}, // padded with zeros
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000}, // flush twice
    '{OP_LOAD,   8'h20, 32'hDEAD_BEEF, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
    '{OP_ENCODE, 8'h20, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000}, // zero length
    '{OP_SPARE,  8'h10, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0000_0000}, // dropped
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000}, // still empty
    '{OP_LOAD,   8'h30, 32'h0000_0005, 6'd3,  1'b0, 3'd0, 32'h0000_0000},
    '{OP_ENCODE, 8'h30, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
    '{OP_ENCODE, 8'h30, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hB400_0000}, // 101101 + pad
    '{OP_LOAD,   8'h55, 32'hFFFF_FFF0, 6'd4,  1'b0, 3'd0, 32'h0000_0000}, // high bits unused
    '{OP_ENCODE, 8'h55, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0000_0000},
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h0000_0000}, // all-zero partial
    '{OP_LOAD,   8'h7F, 32'h8000_0001, 6'd33, 1'b0, 3'd0, 32'h0000_0000}, // saturates too
    '{OP_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000},
    '{OP_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000}, // 32 bits, offset
    '{OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0000_0000}
  };

  logic clk;
  logic rst;

  hte_item_if   item_ch ();
  hte_result_if result_ch ();

  huffman_table_encoder u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Predictor state: own copy of the code table and the bit packer.
  logic [31:0] tbl_bits [SYMBOL_COUNT];
  logic [5:0]  tbl_len  [SYMBOL_COUNT];
  logic [7:0]  acc_byte;
  logic [2:0]  fill_pos;

  // Table entries loaded so far; only these are ever encoded.
  bit          loaded [SYMBOL_COUNT];
  logic [7:0]  loaded_syms [$];

  byte_due_t   packed_bytes_due [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Runs one word through the predictor; returns the number of bytes it
  // completes, packed first byte in [31:24]. The last one carries the mark.
  function automatic int pack_item(input logic [1:0] op, input logic [7:0] sym,
                                   input logic [31:0] code, input logic [5:0] len,
                                   output logic [31:0] bytes);
    int n;
    int j;
    logic [31:0] bits;
    n = 0;
    bytes = '0;
    case (op)
      OP_LOAD: begin
        if (sym < SYMBOL_COUNT) begin
          tbl_bits[sym] = code;
          tbl_len[sym]  = (len > LEN_CAP) ? 6'(LEN_CAP) : len;
        end
      end
      OP_ENCODE: begin
        if (sym < SYMBOL_COUNT) begin
          bits = tbl_bits[sym];
          for (j = int'(tbl_len[sym]); j > 0; j--) begin
            if (bits[j-1]) acc_byte[fill_pos] = 1'b1;
            if (fill_pos == 3'd0) begin
              bytes[31-8*n -: 8] = acc_byte;
              n++;
              acc_byte = '0;
              fill_pos = 3'(TOP_BIT);
            end else begin
              fill_pos = fill_pos - 3'd1;
            end
          end
        end
      end
      OP_FLUSH: begin
        if (fill_pos != 3'(TOP_BIT)) begin
          bytes[31:24] = acc_byte;
          n = 1;
        end
        acc_byte = '0;
        fill_pos = 3'(TOP_BIT);
      end
      default: ;  // spare code: nothing changes
    endcase
    return n;
  endfunction

  // Offers one word after a random gap and waits for it to be taken. The
  // expectation is queued at the accepting edge, ahead of any later word.
  task automatic send_word(input logic [1:0] op, input logic [7:0] sym,
                           input logic [31:0] code, input logic [5:0] len,
                           input bit typed, input int typed_n,
                           input logic [31:0] typed_bytes);
    int n;
    int k;
    logic [31:0] b;
    if (op == OP_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid       = 1'b1;
    item_ch.operation   = op;
    item_ch.symbol      = sym;
    item_ch.code_word   = code;
    item_ch.code_length = len;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    n = pack_item(op, sym, code, len, b);
    if (typed) begin
      n = typed_n;
      b = typed_bytes;
    end
    for (k = 0; k < n; k++)
      packed_bytes_due.push_back('{b[31-8*k -: 8], k == n - 1});
    @(negedge clk);
  endtask

  // Random word: mostly loads and encodes of loaded symbols, with flushes and
  // a little of the spare code mixed in. Returns 0 for a word that is dropped.
  task automatic send_random_word(output bit counted);
    int r;
    int pick;
    logic [5:0] len;
    r = $urandom_range(99);
    counted = 1'b1;
    if (r < 22) begin
      pick = $urandom_range(99);
      if (pick < 5)       len = 6'd0;
      else if (pick < 70) len = 6'($urandom_range(12, 1));
      else if (pick < 90) len = 6'($urandom_range(32, 13));
      else                len = 6'($urandom_range(63, 33));
      send_word(OP_LOAD, 8'($urandom_range(255)), $urandom, len, 1'b0, 0, '0);
    end else if (r < 87) begin
      pick = $urandom_range(loaded_syms.size() - 1);
      send_word(OP_ENCODE, loaded_syms[pick], $urandom, 6'($urandom_range(63)),
                1'b0, 0, '0);
    end else if (r < 96) begin
      send_word(OP_FLUSH, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)),
                1'b0, 0, '0);
    end else begin
      send_word(OP_SPARE, 8'($urandom_range(255)), $urandom, 6'($urandom_range(63)),
                1'b0, 0, '0);
      counted = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input byte_due_t want,
                                 input logic [7:0] got_byte, input logic got_last);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $realtime, what, want.out_byte, want.last_of_run, got_byte, got_last);
  endtask

  // Output side: random back-pressure, updated on the falling edge.
  always @(negedge clk) begin
    result_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Every byte taken is checked against the oldest one due.
  always @(posedge clk) begin
    byte_due_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (packed_bytes_due.size() == 0) begin
        report_mismatch("byte with none due", '0, result_ch.out_byte,
                        result_ch.last_of_run);
      end else begin
        want = packed_bytes_due.pop_front();
        if (want.out_byte !== result_ch.out_byte ||
            want.last_of_run !== result_ch.last_of_run)
          report_mismatch("wrong byte", want, result_ch.out_byte, result_ch.last_of_run);
      end
    end
  end

  // Hard limit, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("huffman_table_encoder test failed");
    $finish;
  end

  initial begin
    int phase;
    int row;
    int issued;
    bit counted;
    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.operation   = OP_LOAD;
    item_ch.symbol      = '0;
    item_ch.code_word   = '0;
    item_ch.code_length = '0;
    result_ch.ready     = 1'b0;
    acc_byte      = '0;
    fill_pos      = 3'(TOP_BIT);
    mismatches    = 0;
    send_idle_pct = 31;
    recv_idle_pct = 79;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Three idle profiles: sender sparse / receiver busy, the reverse, and
    // full rate on both sides.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 31; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase

      if (phase == 0) begin
        for (row = 0; row < N_ROWS; row++)
          send_word(DIRECTED[row].op, DIRECTED[row].sym, DIRECTED[row].code,
                    DIRECTED[row].len, DIRECTED[row].typed,
                    int'(DIRECTED[row].n_bytes), DIRECTED[row].bytes);
      end

      issued = 0;
      while (issued < WORDS_PER_PHASE) begin
        send_random_word(counted);
        if (counted) issued++;
      end

      // Hold the sender off until the packer has handed over every byte.
      item_ch.valid = 1'b0;
      while (packed_bytes_due.size() != 0) @(posedge clk);
      @(negedge clk);
    end

    item_ch.valid = 1'b0;
    while (packed_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && packed_bytes_due.size() == 0) begin
      $display("huffman_table_encoder test passed");
    end else begin
      $display("huffman_table_encoder test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hte_pkg.sv
rtl/hte_if.sv
rtl/hte_ram.sv
rtl/hte_ctrl.sv
rtl/hte_datapath.sv
rtl/huffman_table_encoder.sv
bench/tb_top.sv
